// File: hw/rtl/slab_slot_allocator_core_macros.svh
// Assertion macros for the slab slot allocator.
`ifndef SLAB_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SSA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("slab allocator check failed");
`define SSA_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("slab allocator forbidden condition");
`else
`define SSA_ASSERT(lbl, prop)
`define SSA_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: hw/rtl/ssa_pkg.sv
// Types and constants shared by the slab slot allocator files.
package ssa_pkg;

	localparam int NUM_SLABS = 16;
	localparam int MAX_SLOTS = 64;
	localparam int MAX_RUN   = 32;

	localparam int SLAB_W    = $clog2(NUM_SLABS);
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int LINK_AW   = SLAB_W + SLOT_W;
	localparam int COUNT_W   = 7;
	localparam int TOP_W     = 5;
	localparam int MAPPED_W  = 5;
	localparam int RUN_W     = 6;
	localparam int SPP_W     = 7;
	localparam int LIMIT_W   = 5;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [TOP_W-1:0] TOP_NONE = TOP_W'(NUM_SLABS);

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SLAB = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LIMIT     = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [3:0]        release_slab;
		logic [5:0]        release_slot;
		logic [RUN_W-1:0]  run_request;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [3:0]          granted_slab;
		logic [5:0]          granted_slot;
		logic [RUN_W-1:0]    run_count;
		logic                last;
		logic [MAPPED_W-1:0] slabs_mapped;
	} result_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  head;
		logic [COUNT_W-1:0] count;
		logic [TOP_W-1:0]   plink;
	} slab_rec_t;

endpackage

// File: hw/rtl/ssa_link_ram.sv
// Next-free link memory: one write port and one registered read port.
module ssa_link_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ssa_pkg::LINK_AW-1:0] waddr,
	input  logic [ssa_pkg::SLOT_W-1:0]  wdata,
	input  logic                        re,
	input  logic [ssa_pkg::LINK_AW-1:0] raddr,
	output logic [ssa_pkg::SLOT_W-1:0]  rdata
);

	logic [ssa_pkg::SLOT_W-1:0] mem_q [ssa_pkg::NUM_SLABS*ssa_pkg::MAX_SLOTS];
	logic [ssa_pkg::SLOT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/slab_slot_allocator_core.sv
// Slab slot allocator top level: command sequencer, slab records and link memory.
//
// Usage: a command word is taken at a clock edge where start is high and busy
// is low. Command 0 allocates one slot, 1 releases the slot named by
// release_slab and release_slot, 2 allocates a run of run_request slots (a zero
// counts as one, at most 32), and 3 does nothing. Every result word is shown on
// result for exactly one cycle with result_valid high; the receiver cannot stall,
// so results never wait. The final result of a command has last set.
// Steps: a release reads and updates the named slab in the release state, which
// also shows its result. Each slot taken from an already mapped slab passes a take
// state (a record lookup and a link memory read) and then a link state that shows
// the result; a run repeats these for every slot. Mapping a new slab first writes
// its free list into the link memory one entry per cycle, for the effective
// slots_per_slab entries, and then retries the take. busy falls in the cycle that
// shows the last result, so the next command can be taken at the edge ending it.
// Configuration writes on the cfg channel are always ready; the user must see that
// they are made while the block is idle, which the block does not enforce. Reset
// empties the slab stack, unmaps all slabs and loads slots_per_slab 64 and
// slab_limit 16; no memory clearing is done.
`include "slab_slot_allocator_core_macros.svh"

module slab_slot_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ssa_pkg::request_t              request,
	output logic                           result_valid,
	output ssa_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAKE,
		ST_MAP,
		ST_LINK,
		ST_REL
	} state_t;

	state_t                          state_q;
	ssa_pkg::request_t               req_q;
	logic [ssa_pkg::RUN_W-1:0]       run_len_q;
	logic [ssa_pkg::RUN_W-1:0]       granted_q;
	logic [ssa_pkg::TOP_W-1:0]       top_q;
	logic [ssa_pkg::MAPPED_W-1:0]    mapped_q;
	logic [ssa_pkg::SLOT_W-1:0]      map_i_q;
	logic                            result_valid_q;
	ssa_pkg::result_t                result_q;
	logic [ssa_pkg::SPP_W-1:0]       spp_q;
	logic [ssa_pkg::LIMIT_W-1:0]     limit_q;
	ssa_pkg::slab_rec_t              rec_q [ssa_pkg::NUM_SLABS];

	logic [ssa_pkg::COUNT_W-1:0]     eff_slots;
	logic [ssa_pkg::LIMIT_W-1:0]     eff_limit;
	logic [ssa_pkg::RUN_W-1:0]       run_len;
	logic [ssa_pkg::SLAB_W-1:0]      rec_idx;
	ssa_pkg::slab_rec_t              rec_rd;
	logic                            rec_we;
	logic [ssa_pkg::SLAB_W-1:0]      rec_widx;
	ssa_pkg::slab_rec_t              rec_wdata;
	logic                            link_we;
	logic [ssa_pkg::LINK_AW-1:0]     link_waddr;
	logic [ssa_pkg::SLOT_W-1:0]      link_wdata;
	logic                            link_re;
	logic [ssa_pkg::LINK_AW-1:0]     link_raddr;
	logic [ssa_pkg::SLOT_W-1:0]      link_rdata;
	logic [ssa_pkg::COUNT_W-1:0]     map_next;
	logic                            map_done;
	logic [ssa_pkg::COUNT_W-1:0]     pop_count;
	logic [ssa_pkg::TOP_W-1:0]       pop_top;
	logic [ssa_pkg::RUN_W-1:0]       pop_k;
	logic                            pop_last;
	logic                            rel_bad;
	logic                            rel_no_free;
	logic                            stack_empty;
	logic                            no_room;

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		if (spp_q == '0) begin
			eff_slots = ssa_pkg::COUNT_W'(1);
		end else if (spp_q > ssa_pkg::SPP_W'(ssa_pkg::MAX_SLOTS)) begin
			eff_slots = ssa_pkg::COUNT_W'(ssa_pkg::MAX_SLOTS);
		end else begin
			eff_slots = ssa_pkg::COUNT_W'(spp_q);
		end
		if (limit_q > ssa_pkg::LIMIT_W'(ssa_pkg::NUM_SLABS)) begin
			eff_limit = ssa_pkg::LIMIT_W'(ssa_pkg::NUM_SLABS);
		end else begin
			eff_limit = limit_q;
		end
		if (request.command != ssa_pkg::CMD_RUN || request.run_request == '0) begin
			run_len = ssa_pkg::RUN_W'(1);
		end else if (request.run_request > ssa_pkg::RUN_W'(ssa_pkg::MAX_RUN)) begin
			run_len = ssa_pkg::RUN_W'(ssa_pkg::MAX_RUN);
		end else begin
			run_len = request.run_request;
		end
	end

	// One record read port: the stack top while allocating, the named slab on release.
	assign rec_idx = (state_q == ST_REL) ? req_q.release_slab : top_q[ssa_pkg::SLAB_W-1:0];
	assign rec_rd  = rec_q[rec_idx];

	assign stack_empty  = (top_q >= ssa_pkg::TOP_NONE);
	assign no_room      = (mapped_q >= eff_limit);
	assign map_next     = {1'b0, map_i_q} + ssa_pkg::COUNT_W'(1);
	assign map_done     = (map_next >= eff_slots);
	assign pop_count    = rec_rd.count - ssa_pkg::COUNT_W'(1);
	assign pop_top      = (pop_count == '0) ? rec_rd.plink : top_q;
	assign pop_k        = granted_q + ssa_pkg::RUN_W'(1);
	// The run ends early when the following take is already known to fail.
	assign pop_last     = (pop_k == run_len_q) || ((pop_top >= ssa_pkg::TOP_NONE) && no_room);
	assign rel_bad      = ({1'b0, req_q.release_slab} >= mapped_q) ||
	                      ({1'b0, req_q.release_slot} >= eff_slots);
	assign rel_no_free  = (rec_rd.count == '0);

	always_comb begin
		link_we    = 1'b0;
		link_waddr = {req_q.release_slab, req_q.release_slot};
		link_wdata = rec_rd.head;
		link_re    = 1'b0;
		link_raddr = {top_q[ssa_pkg::SLAB_W-1:0], rec_rd.head};
		rec_we     = 1'b0;
		rec_widx   = rec_idx;
		rec_wdata  = rec_rd;
		case (state_q)
			ST_TAKE: begin
				link_re = !stack_empty;
			end
			ST_MAP: begin
				link_we    = 1'b1;
				link_waddr = {mapped_q[ssa_pkg::SLAB_W-1:0], map_i_q};
				link_wdata = map_done ? '0 : map_next[ssa_pkg::SLOT_W-1:0];
				rec_we     = map_done;
				rec_widx   = mapped_q[ssa_pkg::SLAB_W-1:0];
				rec_wdata.head  = '0;
				rec_wdata.count = eff_slots;
				rec_wdata.plink = top_q;
			end
			ST_LINK: begin
				rec_we          = 1'b1;
				rec_wdata.head  = link_rdata;
				rec_wdata.count = pop_count;
				rec_wdata.plink = (pop_count == '0) ? ssa_pkg::TOP_NONE : rec_rd.plink;
			end
			ST_REL: begin
				link_we         = !rel_bad;
				rec_we          = !rel_bad;
				rec_wdata.head  = req_q.release_slot;
				rec_wdata.count = rec_rd.count + ssa_pkg::COUNT_W'(1);
				rec_wdata.plink = rel_no_free ? top_q : rec_rd.plink;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_q[rec_widx] <= rec_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q   <= ssa_pkg::SPP_W'(64);
			limit_q <= ssa_pkg::LIMIT_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssa_pkg::CFG_SLOTS_PER_SLAB: spp_q   <= cfg_data;
				ssa_pkg::CFG_SLAB_LIMIT:     limit_q <= cfg_data[ssa_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			top_q          <= ssa_pkg::TOP_NONE;
			mapped_q       <= '0;
			result_valid_q <= 1'b0;
			granted_q      <= '0;
			run_len_q      <= '0;
			map_i_q        <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q     <= request;
						run_len_q <= run_len;
						granted_q <= '0;
						case (request.command)
							ssa_pkg::CMD_ALLOC,
							ssa_pkg::CMD_RUN:     state_q <= ST_TAKE;
							ssa_pkg::CMD_RELEASE: state_q <= ST_REL;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TAKE: begin
					if (!stack_empty) begin
						state_q <= ST_LINK;
					end else if (!no_room) begin
						map_i_q <= '0;
						state_q <= ST_MAP;
					end else begin
						if (granted_q == '0) begin
							result_valid_q <= 1'b1;
							result_q <= '{status: ssa_pkg::ST_OOM, granted_slab: '0,
							              granted_slot: '0, run_count: '0, last: 1'b1,
							              slabs_mapped: mapped_q};
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MAP: begin
					map_i_q <= map_next[ssa_pkg::SLOT_W-1:0];
					if (map_done) begin
						top_q    <= mapped_q;
						mapped_q <= mapped_q + ssa_pkg::MAPPED_W'(1);
						state_q  <= ST_TAKE;
					end
				end
				ST_LINK: begin
					top_q          <= pop_top;
					granted_q      <= pop_k;
					result_valid_q <= 1'b1;
					result_q <= '{status: ssa_pkg::ST_OK,
					              granted_slab: top_q[ssa_pkg::SLAB_W-1:0],
					              granted_slot: rec_rd.head, run_count: pop_k,
					              last: pop_last, slabs_mapped: mapped_q};
					state_q <= pop_last ? ST_IDLE : ST_TAKE;
				end
				ST_REL: begin
					if (!rel_bad && rel_no_free) begin
						top_q <= {1'b0, req_q.release_slab};
					end
					result_valid_q <= 1'b1;
					result_q <= '{status: rel_bad ? ssa_pkg::ST_BAD : ssa_pkg::ST_OK,
					              granted_slab: '0, granted_slot: '0, run_count: '0,
					              last: 1'b1, slabs_mapped: mapped_q};
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ssa_link_ram u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// A word comes only from a take, a pop or a release step.
	`SSA_ASSERT(a_result_source, result_valid |-> ($past(state_q) != ST_IDLE && $past(state_q) != ST_MAP))
	// The final word of a command leaves the sequencer idle.
	`SSA_ASSERT(a_last_idle, (result_valid && result.last) |-> (state_q == ST_IDLE))
	// Slabs are mapped one at a time and never beyond the slab count.
	`SSA_ASSERT(a_map_step, (mapped_q != $past(mapped_q)) |-> (mapped_q == $past(mapped_q) + ssa_pkg::MAPPED_W'(1)))
	`SSA_ASSERT_NEVER(a_map_bound, mapped_q > ssa_pkg::MAPPED_W'(ssa_pkg::NUM_SLABS))

endmodule

// File: sim/slab_slot_allocator_monitor.sv
`timescale 1ns / 1ps
// Slab slot allocator monitor: predicts every result word of each command and compares it.
module slab_slot_allocator_monitor
	import ssa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  request_t              request,
	input  logic                  result_valid,
	input  result_t               result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	localparam int REPORT_CAP = 40;

	logic [SLOT_W-1:0]   slab_link [NUM_SLABS*MAX_SLOTS];
	logic [SLOT_W-1:0]   slab_head [NUM_SLABS];
	logic [COUNT_W-1:0]  slab_free [NUM_SLABS];
	logic [TOP_W-1:0]    slab_next_partial [NUM_SLABS];
	logic [TOP_W-1:0]    partial_head;
	logic [MAPPED_W-1:0] slabs_in_use;
	logic [SPP_W-1:0]    cfg_slots;
	logic [LIMIT_W-1:0]  cfg_limit;
	result_t             predicted_words[$];

	initial mismatches = 0;

	function automatic int usable_slots();
		if (cfg_slots == 0) return 1;
		if (cfg_slots > MAX_SLOTS) return MAX_SLOTS;
		return int'(cfg_slots);
	endfunction

	function automatic int slab_cap();
		if (cfg_limit > NUM_SLABS) return NUM_SLABS;
		return int'(cfg_limit);
	endfunction

	// A fresh slab gets the free list 0..n-1 and goes on top of the partial stack.
	function automatic bit map_new_slab();
		int n;
		int i;
		logic [SLAB_W-1:0] s;
		if (slabs_in_use >= slab_cap() || slabs_in_use >= NUM_SLABS) return 1'b0;
		s = slabs_in_use[SLAB_W-1:0];
		n = usable_slots();
		for (i = 0; i < n; i++)
			slab_link[{s, SLOT_W'(i)}] = (i + 1 < n) ? SLOT_W'(i + 1) : '0;
		slab_head[s] = '0;
		slab_free[s] = COUNT_W'(n);
		slab_next_partial[s] = partial_head;
		partial_head = {1'b0, s};
		slabs_in_use = slabs_in_use + 1'b1;
		return 1'b1;
	endfunction

	function automatic bit pop_slot(output logic [3:0] slab, output logic [5:0] slot);
		logic [SLAB_W-1:0] s;
		slab = '0;
		slot = '0;
		if (partial_head >= NUM_SLABS) begin
			if (!map_new_slab()) return 1'b0;
		end
		s = partial_head[SLAB_W-1:0];
		slot = slab_head[s];
		slab_head[s] = slab_link[{s, slot}];
		slab_free[s] = slab_free[s] - 1'b1;
		if (slab_free[s] == 0) begin
			partial_head = slab_next_partial[s];
			slab_next_partial[s] = TOP_NONE;
		end
		slab = s;
		return 1'b1;
	endfunction

	task automatic predict_command(input request_t rq);
		result_t word;
		logic [3:0] slab;
		logic [5:0] slot;
		int want;
		int granted;
		int i;
		bit slab_drained;
		word = '0;
		word.last = 1'b1;
		case (rq.command)
		CMD_ALLOC: begin
			if (pop_slot(slab, slot)) begin
				word.status = ST_OK;
				word.granted_slab = slab;
				word.granted_slot = slot;
				word.run_count = RUN_W'(1);
			end else begin
				word.status = ST_OOM;
			end
			word.slabs_mapped = slabs_in_use;
			predicted_words.push_back(word);
		end
		CMD_RELEASE: begin
			if (rq.release_slab >= slabs_in_use || int'(rq.release_slot) >= usable_slots()) begin
				word.status = ST_BAD;
			end else begin
				slab_drained = (slab_free[rq.release_slab] == 0);
				slab_link[{rq.release_slab, rq.release_slot}] = slab_head[rq.release_slab];
				slab_head[rq.release_slab] = rq.release_slot;
				slab_free[rq.release_slab] = slab_free[rq.release_slab] + 1'b1;
				if (slab_drained) begin
					slab_next_partial[rq.release_slab] = partial_head;
					partial_head = {1'b0, rq.release_slab};
				end
				word.status = ST_OK;
			end
			word.slabs_mapped = slabs_in_use;
			predicted_words.push_back(word);
		end
		CMD_RUN: begin
			if (rq.run_request == 0) want = 1;
			else if (rq.run_request > MAX_RUN) want = MAX_RUN;
			else want = int'(rq.run_request);
			granted = 0;
			for (i = 0; i < want; i++) begin
				if (!pop_slot(slab, slot)) break;
				word.status = ST_OK;
				word.granted_slab = slab;
				word.granted_slot = slot;
				word.run_count = RUN_W'(granted + 1);
				word.last = (i + 1 == want);
				word.slabs_mapped = slabs_in_use;
				predicted_words.push_back(word);
				granted++;
			end
			if (granted == 0) begin
				word = '0;
				word.status = ST_OOM;
				word.last = 1'b1;
				word.slabs_mapped = slabs_in_use;
				predicted_words.push_back(word);
			end else begin
				// A run cut short by out of memory still marks its final slot.
				predicted_words[predicted_words.size() - 1].last = 1'b1;
			end
		end
		default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		if (predicted_words.size() == 0) begin
			report_mismatch($sformatf("result word %h arrived with none predicted", got));
			return;
		end
		want = predicted_words.pop_front();
		compare_field("status", got.status, want.status);
		compare_field("granted_slab", got.granted_slab, want.granted_slab);
		compare_field("granted_slot", got.granted_slot, want.granted_slot);
		compare_field("run_count", got.run_count, want.run_count);
		compare_field("last", got.last, want.last);
		compare_field("slabs_mapped", got.slabs_mapped, want.slabs_mapped);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_words.delete();
			partial_head = TOP_NONE;
			slabs_in_use = '0;
			cfg_slots = SPP_W'(64);
			cfg_limit = LIMIT_W'(16);
			pending <= 0;
		end else begin
			// Words out at this edge belong to earlier commands, so check before predicting.
			if (result_valid) check_word(result);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_SLOTS_PER_SLAB: cfg_slots = cfg_data[SPP_W-1:0];
				CFG_SLAB_LIMIT: cfg_limit = cfg_data[LIMIT_W-1:0];
				default: ;
				endcase
			end
			if (start && !busy) predict_command(request);
			pending <= predicted_words.size();
		end
	end

endmodule

// File: sim/slab_slot_allocator_core_test.sv
`timescale 1ns / 1ps
// Slab slot allocator testbench top: clock, reset, command stimulus and the verdict.
module slab_slot_allocator_core_test;
	import ssa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 80;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	request_t              request = '0;
	logic                  result_valid;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatches;
	int                    pending;
	int unsigned           cycle_count = 0;
	logic [LINK_AW-1:0]    live_handles[$];

	slab_slot_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	slab_slot_allocator_monitor alloc_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("slab_slot_allocator_core regression: fail");
			$finish;
		end
	end

	// Granted slots are collected mid-cycle so that later releases can hand them back.
	always @(negedge clk) begin
		if (arst_n && result_valid && result.status == ST_OK && result.run_count != 0)
			live_handles.push_back({result.granted_slab, result.granted_slot});
	end

	function automatic request_t req_word(input logic [CMD_W-1:0] cmd, input int slab,
			input int slot, input int count);
		request_t rq;
		rq.command = cmd;
		rq.release_slab = 4'(slab);
		rq.release_slot = 6'(slot);
		rq.run_request = RUN_W'(count);
		return rq;
	endfunction

	// Mostly well-formed traffic: allocations, short runs and releases of held slots,
	// with a little noise in the form of arbitrary releases and the unused command.
	function automatic request_t random_request();
		request_t rq;
		int pick;
		int k;
		logic [LINK_AW-1:0] handle;
		rq.command = CMD_ALLOC;
		rq.release_slab = 4'($urandom);
		rq.release_slot = 6'($urandom);
		rq.run_request = RUN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 36) begin
			rq.command = CMD_ALLOC;
		end else if (pick < 56) begin
			rq.command = CMD_RUN;
			if ($urandom_range(9) != 0) rq.run_request = RUN_W'($urandom_range(1, 6));
		end else if (pick < 94 && live_handles.size() != 0) begin
			k = $urandom_range(live_handles.size() - 1);
			handle = live_handles[k];
			live_handles.delete(k);
			rq.command = CMD_RELEASE;
			rq.release_slab = handle[LINK_AW-1:SLOT_W];
			rq.release_slot = handle[SLOT_W-1:0];
		end else if (pick < 97) begin
			rq.command = CMD_RELEASE;
		end else begin
			rq.command = CMD_IDLE;
		end
		return rq;
	endfunction

	task automatic configure(input int slots, input int limit);
		cfg_index <= CFG_SLOTS_PER_SLAB;
		cfg_data <= CFG_DATA_W'(slots);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_SLAB_LIMIT;
		cfg_data <= CFG_DATA_W'(limit);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic issue(input request_t rq, input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		request <= rq;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Holds off the next word until every predicted result has come and the block is idle.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int slots, input int limit, input int idle_pct,
			input int count);
		request_t rq;
		int sent;
		configure(slots, limit);
		sent = 0;
		while (sent < count) begin
			rq = random_request();
			issue(rq, idle_pct);
			if (rq.command != CMD_IDLE) sent++;
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No slabs may be mapped: everything runs out of memory or is a bad handle.
		configure(0, 0);
		issue(req_word(CMD_ALLOC, 15, 63, 63), 0);
		issue(req_word(CMD_RUN, 0, 0, 0), 0);
		issue(req_word(CMD_RELEASE, 0, 0, 1), 0);
		issue(req_word(CMD_IDLE, 15, 63, 63), 0);
		drain();

		// A zero slot count maps one-slot slabs.
		configure(0, 1);
		issue(req_word(CMD_ALLOC, 0, 0, 1), 0);
		issue(req_word(CMD_ALLOC, 0, 0, 1), 0);
		issue(req_word(CMD_RELEASE, 0, 1, 1), 0);
		issue(req_word(CMD_RELEASE, 0, 0, 1), 0);
		issue(req_word(CMD_RUN, 0, 0, 2), 0);
		drain();

		// Runs cut short by the limit, bad handles, and a slot freed twice.
		configure(3, 2);
		issue(req_word(CMD_ALLOC, 0, 0, 1), 0);
		issue(req_word(CMD_RUN, 0, 0, 63), 0);
		issue(req_word(CMD_RELEASE, 1, 2, 1), 0);
		issue(req_word(CMD_RELEASE, 15, 0, 1), 0);
		issue(req_word(CMD_RELEASE, 1, 63, 1), 0);
		issue(req_word(CMD_RELEASE, 0, 0, 1), 0);
		issue(req_word(CMD_ALLOC, 0, 0, 1), 0);
		issue(req_word(CMD_RELEASE, 1, 1, 1), 0);
		issue(req_word(CMD_RELEASE, 1, 1, 1), 0);
		issue(req_word(CMD_ALLOC, 0, 0, 1), 0);
		issue(req_word(CMD_ALLOC, 0, 0, 1), 0);
		issue(req_word(CMD_RUN, 0, 0, 32), 0);
		issue(req_word(CMD_RELEASE, 1, 2, 1), 0);
		drain();

		run_phase(1, 6, 0, 75);
		run_phase($urandom_range(8, 63), 10, 73, 75);
		run_phase(127, 31, 0, 75);
		run_phase(64, 16, 7, 75);

		if (mismatches == 0 && pending == 0)
			$display("slab_slot_allocator_core regression: pass");
		else
			$display("slab_slot_allocator_core regression: fail");
		$finish;
	end

endmodule
